@@ hw/rtl/fsd_pkg.sv @@
// Shared types and constants of the framebuffer shape drawer.
`default_nettype none

package fsd_pkg;

	// Command codes carried in the action field.
	localparam logic [2:0] ACT_READ   = 3'd0;
	localparam logic [2:0] ACT_SET    = 3'd1;
	localparam logic [2:0] ACT_FILL   = 3'd2;
	localparam logic [2:0] ACT_SQUARE = 3'd3;
	localparam logic [2:0] ACT_CIRCLE = 3'd4;

	// Configuration register indexes.
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Field widths.
	localparam int ACTION_W = 3;
	localparam int POS_W    = 6;
	localparam int SIZE_W   = 6;
	localparam int CHAN_W   = 8;
	localparam int DIM_W    = 7;
	localparam int PIXEL_W  = 4 * CHAN_W;

	// Input beat: the fields packed from the lowest bit up, padded to whole bytes.
	localparam int IN_FIELDS_W = ACTION_W + 2 * POS_W + SIZE_W + PIXEL_W;
	localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

	// Reset value of both frame dimension registers.
	localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

	// Signed scan coordinate: covers a circle box left of column 0 and a
	// frame edge up to 126.
	localparam int COORD_W = 8;
	typedef logic signed [COORD_W-1:0] coord_t;

	// Radius plus one, squared.
	localparam int LIM_W = 2 * (SIZE_W + 1);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the accepted input beat
		logic setup;      // work out and register the clipped scan box
		logic scan_start; // start the pixel scan over the box
		logic out_load;   // move the read result into the output register
	} fsd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clearing;   // the reset clearing pass is still running
		logic busy;       // scan or pixel stage still has work in flight
		logic box_empty;  // the clipped box holds no pixel
		logic is_read;    // the held command is a pixel read
		logic act_known;  // the held command code is one of the five commands
		logic out_free;   // the output register can take a result this cycle
	} fsd_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/fsd_ctrl.sv @@
// Command sequencer of the framebuffer shape drawer.
`default_nettype none

module fsd_ctrl
	import fsd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	output fsd_cmd_t         cmd,
	input  wire fsd_status_t status
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_BRANCH,
		ST_RUN,
		ST_RESP
	} state_t;

	state_t state_q;
	logic   ready_q;

	// Commands decoded from the current state.
	assign s_tready       = ready_q;
	assign cmd.load       = s_tvalid & ready_q;
	assign cmd.setup      = (state_q == ST_SETUP);
	assign cmd.scan_start = (state_q == ST_BRANCH) & status.act_known & ~status.box_empty;
	assign cmd.out_load   = (state_q == ST_RESP) & status.out_free;

	// State register and the registered ready flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ready_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (!status.clearing) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_IDLE: begin
					if (s_tvalid && ready_q) begin
						state_q <= ST_SETUP;
						ready_q <= 1'b0;
					end
				end
				ST_SETUP: begin
					state_q <= ST_BRANCH;
				end
				ST_BRANCH: begin
					// Unknown codes and empty drawing boxes finish at once; an
					// out-of-frame read still answers.
					if (!status.act_known) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end else if (status.box_empty) begin
						if (status.is_read) begin
							state_q <= ST_RESP;
						end else begin
							state_q <= ST_IDLE;
							ready_q <= 1'b1;
						end
					end else begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (!status.busy) begin
						if (status.is_read) begin
							state_q <= ST_RESP;
						end else begin
							state_q <= ST_IDLE;
							ready_q <= 1'b1;
						end
					end
				end
				ST_RESP: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
					ready_q <= 1'b0;
				end
			endcase
		end
	end

	// No beat is taken before the frame store is clear.
	a_no_ready_while_clearing: assert property (
		@(posedge clk) disable iff (!arst_n) status.clearing |-> !s_tready
	) else $error("input ready while the frame store is being cleared");

	// A command in progress blocks the input.
	a_no_ready_while_running: assert property (
		@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN || state_q == ST_RESP) |-> !ready_q
	) else $error("input ready while a command is still in progress");

	// A scan starts only with the pixel pipeline empty.
	a_scan_starts_idle: assert property (
		@(posedge clk) disable iff (!arst_n) cmd.scan_start |-> !status.busy
	) else $error("scan started with pixel work still in flight");

endmodule

`default_nettype wire

@@ hw/rtl/fsd_datapath.sv @@
// Datapath of the framebuffer shape drawer: registers, scan box, pixel stage and frame store.
`default_nettype none

module fsd_datapath
	import fsd_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	input  wire logic [IN_DATA_W-1:0] in_data,
	input  wire fsd_cmd_t             cmd,
	output fsd_status_t               status,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [PIXEL_W-1:0]        out_data,
	output logic                      out_in_bounds
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = (AW > 2 * DIM_W + 1) ? AW : 2 * DIM_W + 1;
	localparam logic [DIM_W-1:0] W_CAP = DIM_W'((MAX_WIDTH > 127) ? 127 : MAX_WIDTH);
	localparam logic [DIM_W-1:0] H_CAP = DIM_W'((MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT);

	// Configuration registers.
	logic [DIM_W-1:0] frame_width_q;
	logic [DIM_W-1:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= DIM_RESET;
			frame_height_q <= DIM_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_WIDTH) begin
				frame_width_q <= cfg_data;
			end else begin
				frame_height_q <= cfg_data;
			end
		end
	end

	// Dimensions in use, capped at the store size.
	logic [DIM_W-1:0] eff_w;
	logic [DIM_W-1:0] eff_h;
	coord_t           w_last;
	coord_t           h_last;

	assign eff_w  = (frame_width_q > W_CAP) ? W_CAP : frame_width_q;
	assign eff_h  = (frame_height_q > H_CAP) ? H_CAP : frame_height_q;
	assign w_last = coord_t'({1'b0, eff_w}) - coord_t'(1);
	assign h_last = coord_t'({1'b0, eff_h}) - coord_t'(1);

	// Command register, loaded on the accepted beat.
	logic [ACTION_W-1:0] act_q;
	logic [POS_W-1:0]    px_q;
	logic [POS_W-1:0]    py_q;
	logic [SIZE_W-1:0]   size_q;
	logic [PIXEL_W-1:0]  colour_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q    <= in_data[ACTION_W-1:0];
			px_q     <= in_data[ACTION_W +: POS_W];
			py_q     <= in_data[ACTION_W + POS_W +: POS_W];
			size_q   <= in_data[ACTION_W + 2 * POS_W +: SIZE_W];
			colour_q <= in_data[ACTION_W + 2 * POS_W + SIZE_W +: PIXEL_W];
		end
	end

	// Raw box of the command, then clipped to the frame in use.
	coord_t px_c, py_c, sz_c;
	coord_t xs, xe, ys, ye;
	coord_t cxs, cxe, cys, cye;
	logic [SIZE_W:0]  size_p1;
	logic [LIM_W-1:0] lim;

	assign px_c    = coord_t'({2'b00, px_q});
	assign py_c    = coord_t'({2'b00, py_q});
	assign sz_c    = coord_t'({2'b00, size_q});
	assign size_p1 = {1'b0, size_q} + (SIZE_W + 1)'(1);
	assign lim     = LIM_W'(size_p1) * LIM_W'(size_p1);

	always_comb begin
		case (act_q)
			ACT_FILL: begin
				xs = '0;
				xe = w_last;
				ys = '0;
				ye = h_last;
			end
			ACT_SQUARE: begin
				xs = px_c;
				xe = px_c + sz_c - coord_t'(1);
				ys = py_c;
				ye = py_c + sz_c - coord_t'(1);
			end
			ACT_CIRCLE: begin
				xs = px_c - sz_c;
				xe = px_c + sz_c;
				ys = py_c - sz_c;
				ye = py_c + sz_c;
			end
			default: begin
				xs = px_c;
				xe = px_c;
				ys = py_c;
				ye = py_c;
			end
		endcase
		cxs = (xs < coord_t'(0)) ? coord_t'(0) : xs;
		cys = (ys < coord_t'(0)) ? coord_t'(0) : ys;
		cxe = (xe > w_last) ? w_last : xe;
		cye = (ye > h_last) ? h_last : ye;
	end

	coord_t           xs_q, xe_q, ys_q, ye_q;
	logic             empty_q;
	logic [LIM_W-1:0] lim_q;

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			xs_q    <= cxs;
			xe_q    <= cxe;
			ys_q    <= cys;
			ye_q    <= cye;
			empty_q <= (cxs > cxe) || (cys > cye);
			lim_q   <= lim;
		end
	end

	// Raster scanner: one pixel of the box a cycle.
	coord_t scan_x_q, scan_y_q;
	logic   scan_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_v_q <= 1'b0;
		end else if (cmd.scan_start) begin
			scan_v_q <= 1'b1;
		end else if (scan_v_q && scan_x_q == xe_q && scan_y_q == ye_q) begin
			scan_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			scan_x_q <= xs_q;
			scan_y_q <= ys_q;
		end else if (scan_v_q) begin
			if (scan_x_q == xe_q) begin
				scan_x_q <= xs_q;
				scan_y_q <= scan_y_q + coord_t'(1);
			end else begin
				scan_x_q <= scan_x_q + coord_t'(1);
			end
		end
	end

	// Pixel stage: circle test and store address of the scanned pixel.
	coord_t                   dx, dy;
	logic signed [15:0]       dx2, dy2;
	logic [15:0]              dist2;
	logic                     hit;
	logic [IW-1:0]            idx_full;
	logic                     is_read;

	assign dx       = scan_x_q - px_c;
	assign dy       = scan_y_q - py_c;
	assign dx2      = 16'(dx) * 16'(dx);
	assign dy2      = 16'(dy) * 16'(dy);
	assign dist2    = 16'(dx2 + dy2);
	assign hit      = (act_q != ACT_CIRCLE) || (dist2 < 16'(lim_q));
	assign idx_full = IW'(scan_y_q[DIM_W-1:0]) * IW'(eff_w) + IW'(scan_x_q[DIM_W-1:0]);
	assign is_read  = (act_q == ACT_READ);

	logic          we_s2;
	logic          re_s2;
	logic [AW-1:0] addr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_s2 <= 1'b0;
			re_s2 <= 1'b0;
		end else begin
			we_s2 <= scan_v_q & hit & ~is_read;
			re_s2 <= scan_v_q & is_read;
		end
	end

	always_ff @(posedge clk) begin
		addr_s2 <= idx_full[AW-1:0];
	end

	// Clearing pass after reset: one pixel a cycle over the whole store.
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Frame store, single port with registered read data.
	logic [PIXEL_W-1:0] mem [DEPTH];
	logic [PIXEL_W-1:0] rd_q;
	logic               mem_we;
	logic [AW-1:0]      mem_addr;
	logic [PIXEL_W-1:0] mem_wdata;

	assign mem_we    = clearing_q | we_s2;
	assign mem_addr  = clearing_q ? clr_addr_q : addr_s2;
	assign mem_wdata = clearing_q ? '0 : colour_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (re_s2) begin
			rd_q <= mem[mem_addr];
		end
	end

	// Output register for the read result.
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data      <= empty_q ? '0 : rd_q;
			out_in_bounds <= ~empty_q;
		end
	end

	assign out_valid = out_valid_q;

	// Status back to the controller.
	assign status.clearing  = clearing_q;
	assign status.busy      = scan_v_q | we_s2 | re_s2;
	assign status.box_empty = empty_q;
	assign status.is_read   = is_read;
	assign status.act_known = (act_q <= ACT_CIRCLE);
	assign status.out_free  = ~out_valid_q | out_ready;

	// Drawing never competes with the clearing pass for the store port.
	a_no_draw_while_clearing: assert property (
		@(posedge clk) disable iff (!arst_n) clearing_q |-> !scan_v_q && !we_s2 && !re_s2
	) else $error("pixel work in flight during the clearing pass");

	// The scanner stays inside the clipped box.
	a_scan_in_box: assert property (
		@(posedge clk) disable iff (!arst_n)
		scan_v_q |-> scan_x_q >= xs_q && scan_x_q <= xe_q && scan_y_q >= ys_q
			&& scan_y_q <= ye_q && scan_x_q >= coord_t'(0) && scan_y_q >= coord_t'(0)
	) else $error("scan position left the clipped box");

	// A result is loaded only into a free output register.
	a_out_load_free: assert property (
		@(posedge clk) disable iff (!arst_n) cmd.out_load |-> (!out_valid_q || out_ready)
	) else $error("read result overwrote a waiting beat");

endmodule

`default_nettype wire

@@ hw/rtl/framebuffer_shape_drawer.sv @@
// Top level of the framebuffer shape drawer: controller, datapath and port packing.
//
// A 32-bit RGBA frame store of MAX_WIDTH x MAX_HEIGHT pixels, drawn by commands
// on the slave stream (s_*) and answered on the master stream (m_*). Each input
// beat is one command: read pixel, set pixel, fill, square or circle. Only a
// read produces an output beat, carrying the pixel and an in-bounds flag.
// Frame width and height are written on the cfg_* port, which the user must
// do only while the block is idle; the block itself does not enforce this.
// Commands run one at a time. The drawing box is clipped to the frame first,
// and its pixels then pass through the scanner one per cycle. The single store
// port sets this rate. After reset the store is cleared, one pixel per cycle
// over all MAX_WIDTH * MAX_HEIGHT pixels (4096 by default); s_tready stays
// low until then, while configuration writes are taken. A read result waits
// in the output register when m_tready is low; further commands are still
// accepted, but the next read holds until that register is free.
`default_nettype none

module framebuffer_shape_drawer
	import fsd_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Configuration writes.
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	// Command stream.
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// action[2:0], pos_x[8:3], pos_y[14:9], shape_size[20:15], red_in[28:21],
	// green_in[36:29], blue_in[44:37], alpha_in[52:45], zero padding above
	input  wire logic [IN_DATA_W-1:0] s_tdata,
	// Read result stream.
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// red_out[7:0], green_out[15:8], blue_out[23:16], alpha_out[31:24]
	output logic [PIXEL_W-1:0]        m_tdata,
	// in_bounds[0]
	output logic                      m_tuser
);

	fsd_cmd_t    cmd;
	fsd_status_t status;

	fsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.status   (status)
	);

	fsd_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_data       (s_tdata),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_data      (m_tdata),
		.out_in_bounds (m_tuser)
	);

endmodule

`default_nettype wire
